// File: rtl/snrt_pkg.sv
`default_nettype none
package snrt_pkg;
	localparam int DEPTH_DEF = 32;
	localparam int KEY_W = 152;
	localparam int PHONE_W = 32;

	typedef logic [1:0] func_t;
	localparam func_t FN_INSERT = 2'd0;
	localparam func_t FN_LIST   = 2'd1;
	localparam func_t FN_SEARCH = 2'd2;
	localparam func_t FN_DELETE = 2'd3;

	typedef logic [1:0] status_t;
	localparam status_t ST_OK       = 2'd0;
	localparam status_t ST_NOTFOUND = 2'd1;
	localparam status_t ST_EMPTY    = 2'd2;
	localparam status_t ST_FULL     = 2'd3;

	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [PHONE_W-1:0] phone;
	} rec_t;

	// per-cycle command broadcast to every cell
	typedef enum logic [2:0] {
		OP_HOLD,
		OP_LOAD,
		OP_SORT_EVEN,
		OP_SORT_ODD,
		OP_SHIFT_UP,
		OP_SHIFT_DOWN
	} op_t;

	typedef struct packed {
		op_t              op;
		rec_t             load_rec;
		logic [KEY_W-1:0] probe;
	} cell_ctl_t;
endpackage
`default_nettype wire

// File: rtl/snrt_if.sv
`default_nettype none
interface snrt_in_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    func;
	logic [63:0]                   key_hi;
	logic [63:0]                   key_mid;
	logic [23:0]                   key_lo;
	logic signed [31:0]            phone_in;
	modport source (output valid, func, key_hi, key_mid, key_lo, phone_in, input ready);
	modport sink (input valid, func, key_hi, key_mid, key_lo, phone_in, output ready);
endinterface

interface snrt_out_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic [63:0]        rec_hi;
	logic [63:0]        rec_mid;
	logic [23:0]        rec_lo;
	logic signed [31:0] phone_out;
	logic               last;
	modport source (output valid, status, rec_hi, rec_mid, rec_lo, phone_out, last,
		input ready);
	modport sink (input valid, status, rec_hi, rec_mid, rec_lo, phone_out, last,
		output ready);
endinterface
`default_nettype wire

// File: rtl/snrt_cell.sv
`default_nettype none
// one table slot; talks only to its two neighbors
module snrt_cell (
	input  wire logic              clk,
	input  wire snrt_pkg::cell_ctl_t ctl,
	input  wire logic              sel,
	input  wire logic              even,
	input  wire snrt_pkg::rec_t    lower,
	input  wire snrt_pkg::rec_t    upper,
	input  wire logic              upper_ok,
	input  wire logic              lower_ok,
	output snrt_pkg::rec_t         rec,
	output logic                   match
);
	snrt_pkg::rec_t rec_q;
	logic gt_up, lt_dn, pair_lead;

	assign rec = rec_q;
	assign match = (rec_q.key == ctl.probe);
	assign gt_up = rec_q.key > upper.key;
	assign lt_dn = lower.key > rec_q.key;
	assign pair_lead = (ctl.op == snrt_pkg::OP_SORT_EVEN) ? even : !even;

	always_ff @(posedge clk) begin
		unique case (ctl.op)
			snrt_pkg::OP_LOAD: begin
				if (sel) rec_q <= ctl.load_rec;
			end
			snrt_pkg::OP_SORT_EVEN, snrt_pkg::OP_SORT_ODD: begin
				if (pair_lead) begin
					if (upper_ok && gt_up) rec_q <= upper;
				end else begin
					if (lower_ok && lt_dn) rec_q <= lower;
				end
			end
			snrt_pkg::OP_SHIFT_DOWN: begin
				if (sel) rec_q <= upper;
			end
			default: begin
			end
		endcase
	end
endmodule
`default_nettype wire

// File: rtl/sorted_name_record_table_core.sv
`default_nettype none
// table of name/phone records held in a row of cells, one record per cell.
// in: func, key_hi/mid/lo, phone_in.  out: status, record, last.
// insert: loads the cell at the count on the accepting edge; the result is
// valid in the cycle after acceptance.
// search/delete: every cell compares at once in the find cycle; on a hit,
// delete shifts the upper cells down by one in that same cycle. the result
// is registered at the end of the find cycle.
// list: odd-even transposition sort, count+1 passes, one per cycle, then
// one result per cycle while out.ready is high, read out through a mux.
// empty table and full table answers take the insert timing.
// one item at a time: in.ready is high only while idle.
// the result waits in an output register while out.ready is low; the table
// holds still meanwhile. reset clears the count and control; cell contents
// are undefined until written.
module sorted_name_record_table_core #(
	parameter int DEPTH = snrt_pkg::DEPTH_DEF
) (
	input wire logic   clk,
	input wire logic   arst_n,
	snrt_in_if.sink    in,
	snrt_out_if.source out
);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = $clog2(DEPTH);

	typedef enum logic [2:0] {S_IDLE, S_FIND, S_SORT, S_LIST, S_OUT} state_t;
	state_t state_q;

	logic [CW-1:0] count_q, pass_q, idx_q;
	logic [1:0] func_q;
	logic [snrt_pkg::KEY_W-1:0] probe_q;
	snrt_pkg::cell_ctl_t ctl;
	snrt_pkg::rec_t recs [DEPTH];
	logic [DEPTH-1:0] match, valid_c, first_m, shift_sel, load_sel;
	logic found;
	logic [IW-1:0] hit_idx;

	always_comb begin
		valid_c = '0;
		for (int i = 0; i < DEPTH; i++) valid_c[i] = (CW'(i) < count_q);
	end
	assign first_m = (match & valid_c) & ~((match & valid_c) - DEPTH'(1));
	assign found = |(match & valid_c);
	always_comb begin
		hit_idx = '0;
		for (int i = 0; i < DEPTH; i++) if (first_m[i]) hit_idx = IW'(i);
	end
	// cells at and above the hit take their upper neighbor
	assign shift_sel = ~(first_m - DEPTH'(1));
	always_comb begin
		load_sel = '0;
		for (int i = 0; i < DEPTH; i++) load_sel[i] = (CW'(i) == count_q);
	end

	always_comb begin
		ctl.op = snrt_pkg::OP_HOLD;
		ctl.load_rec.key = {in.key_hi, in.key_mid, in.key_lo};
		ctl.load_rec.phone = in.phone_in;
		ctl.probe = probe_q;
		if (state_q == S_IDLE && in.valid && in.func == snrt_pkg::FN_INSERT
			&& count_q != CW'(DEPTH))
			ctl.op = snrt_pkg::OP_LOAD;
		else if (state_q == S_SORT)
			ctl.op = pass_q[0] ? snrt_pkg::OP_SORT_ODD : snrt_pkg::OP_SORT_EVEN;
		else if (state_q == S_FIND && func_q == snrt_pkg::FN_DELETE && found)
			ctl.op = snrt_pkg::OP_SHIFT_DOWN;
	end

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		snrt_pkg::rec_t up_r, dn_r;
		if (g + 1 < DEPTH) begin : g_up
			assign up_r = recs[g+1];
		end else begin : g_top
			assign up_r = recs[g];
		end
		if (g > 0) begin : g_dn
			assign dn_r = recs[g-1];
		end else begin : g_bot
			assign dn_r = recs[g];
		end
		snrt_cell u_cell (
			.clk(clk), .ctl(ctl),
			.sel(ctl.op == snrt_pkg::OP_LOAD ? load_sel[g] : shift_sel[g]),
			.even(g % 2 == 0), .lower(dn_r), .upper(up_r),
			.upper_ok(CW'(g + 1) < count_q), .lower_ok(g > 0),
			.rec(recs[g]), .match(match[g])
		);
	end

	assign in.ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			pass_q <= '0;
			idx_q <= '0;
			func_q <= '0;
			probe_q <= '0;
			out.valid <= 1'b0;
			out.status <= snrt_pkg::ST_OK;
			out.rec_hi <= '0;
			out.rec_mid <= '0;
			out.rec_lo <= '0;
			out.phone_out <= '0;
			out.last <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: if (in.valid) begin
					func_q <= in.func;
					probe_q <= {in.key_hi, in.key_mid, in.key_lo};
					out.rec_hi <= '0; out.rec_mid <= '0; out.rec_lo <= '0;
					out.phone_out <= '0; out.last <= 1'b1;
					if (in.func == snrt_pkg::FN_INSERT) begin
						out.valid <= 1'b1; state_q <= S_OUT;
						if (count_q == CW'(DEPTH)) out.status <= snrt_pkg::ST_FULL;
						else begin
							out.status <= snrt_pkg::ST_OK;
							count_q <= count_q + CW'(1);
						end
					end else if (count_q == '0) begin
						out.status <= snrt_pkg::ST_EMPTY;
						out.valid <= 1'b1; state_q <= S_OUT;
					end else if (in.func == snrt_pkg::FN_LIST) begin
						pass_q <= '0; state_q <= S_SORT;
					end else state_q <= S_FIND;
				end
				S_FIND: begin
					out.valid <= 1'b1; state_q <= S_OUT;
					if (found) begin
						out.status <= snrt_pkg::ST_OK;
						{out.rec_hi, out.rec_mid, out.rec_lo} <= recs[hit_idx].key;
						out.phone_out <= recs[hit_idx].phone;
						if (func_q == snrt_pkg::FN_DELETE) count_q <= count_q - CW'(1);
					end else out.status <= snrt_pkg::ST_NOTFOUND;
				end
				S_SORT: begin
					pass_q <= pass_q + CW'(1);
					if (pass_q == count_q) begin
						idx_q <= '0; state_q <= S_LIST;
					end
				end
				S_LIST: if (!out.valid || out.ready) begin
					if (idx_q == count_q) begin
						if (out.ready) begin out.valid <= 1'b0; state_q <= S_IDLE; end
					end else begin
						out.valid <= 1'b1;
						out.status <= snrt_pkg::ST_OK;
						{out.rec_hi, out.rec_mid, out.rec_lo} <= recs[idx_q[IW-1:0]].key;
						out.phone_out <= recs[idx_q[IW-1:0]].phone;
						out.last <= (idx_q + CW'(1) == count_q);
						idx_q <= idx_q + CW'(1);
					end
				end
				S_OUT: if (out.ready) begin
					out.valid <= 1'b0; state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// File: rtl/snrt_checker.sv
`default_nettype none
module snrt_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic out_last,
	input wire snrt_pkg::status_t out_status
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("out item dropped");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("ready while result pending");
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_status != snrt_pkg::ST_OK |-> out_last)
		else $error("error not last");
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready) else $error("took two items");
endmodule

bind sorted_name_record_table_core snrt_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in.valid), .in_ready(in.ready),
	.out_valid(out.valid), .out_ready(out.ready), .out_last(out.last),
	.out_status(out.status)
);
`default_nettype wire

// File: verif/tb_if_note.sv
package tb_snrt_pkg;
	typedef struct {
		snrt_pkg::status_t status;
		logic [63:0]       hi;
		logic [63:0]       mid;
		logic [23:0]       lo;
		logic [31:0]       phone;
		logic              last;
	} answer_t;
endpackage

// File: verif/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = snrt_pkg::DEPTH_DEF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	snrt_in_if  req();
	snrt_out_if rsp();

	sorted_name_record_table_core #(.DEPTH(DEPTH)) uut (
		.clk(clk), .arst_n(arst_n), .in(req), .out(rsp)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// predictor state
	logic [63:0] tab_hi[DEPTH];
	logic [63:0] tab_mid[DEPTH];
	logic [23:0] tab_lo[DEPTH];
	logic [31:0] tab_ph[DEPTH];
	int          tab_n = 0;
	tb_snrt_pkg::answer_t pending[$];
	int          errors = 0;
	int          send_idle = 7;
	int          recv_idle = 84;
	int          hold_off = 0;

	// names drawn from a small pool so searches and deletes hit
	logic [63:0] pool_hi[8];
	logic [63:0] pool_mid[8];
	logic [23:0] pool_lo[8];

	function automatic int name_order(logic [63:0] ah, logic [63:0] am, logic [23:0] al,
		logic [63:0] bh, logic [63:0] bm, logic [23:0] bl);
		if ({ah, am, al} > {bh, bm, bl}) return 1;
		if ({ah, am, al} < {bh, bm, bl}) return -1;
		return 0;
	endfunction

	function automatic tb_snrt_pkg::answer_t mk(snrt_pkg::status_t s, int idx, bit rec,
		bit lst);
		tb_snrt_pkg::answer_t a;
		a.status = s;
		a.hi = rec ? tab_hi[idx] : '0;
		a.mid = rec ? tab_mid[idx] : '0;
		a.lo = rec ? tab_lo[idx] : '0;
		a.phone = rec ? tab_ph[idx] : '0;
		a.last = lst;
		return a;
	endfunction

	task automatic predict_table(snrt_pkg::func_t f, logic [63:0] h, logic [63:0] m,
		logic [23:0] l, logic [31:0] p);
		int i;
		int j;
		int k;
		logic [63:0] th;
		logic [63:0] tm;
		logic [23:0] tl;
		logic [31:0] tp;
		if (f == snrt_pkg::FN_INSERT) begin
			if (tab_n >= DEPTH) pending.push_back(mk(snrt_pkg::ST_FULL, 0, 0, 1));
			else begin
				tab_hi[tab_n] = h; tab_mid[tab_n] = m; tab_lo[tab_n] = l; tab_ph[tab_n] = p;
				tab_n++;
				pending.push_back(mk(snrt_pkg::ST_OK, 0, 0, 1));
			end
		end else if (tab_n == 0) begin
			pending.push_back(mk(snrt_pkg::ST_EMPTY, 0, 0, 1));
		end else if (f == snrt_pkg::FN_LIST) begin
			for (i = 1; i < tab_n; i++)
				for (j = 0; j + 1 < tab_n; j++)
					if (name_order(tab_hi[j], tab_mid[j], tab_lo[j],
						tab_hi[j+1], tab_mid[j+1], tab_lo[j+1]) > 0) begin
						th = tab_hi[j]; tm = tab_mid[j]; tl = tab_lo[j]; tp = tab_ph[j];
						tab_hi[j] = tab_hi[j+1]; tab_mid[j] = tab_mid[j+1];
						tab_lo[j] = tab_lo[j+1]; tab_ph[j] = tab_ph[j+1];
						tab_hi[j+1] = th; tab_mid[j+1] = tm; tab_lo[j+1] = tl; tab_ph[j+1] = tp;
					end
			for (i = 0; i < tab_n; i++)
				pending.push_back(mk(snrt_pkg::ST_OK, i, 1, i + 1 == tab_n));
		end else begin
			k = tab_n;
			for (i = tab_n - 1; i >= 0; i--)
				if (name_order(tab_hi[i], tab_mid[i], tab_lo[i], h, m, l) == 0) k = i;
			if (k == tab_n) pending.push_back(mk(snrt_pkg::ST_NOTFOUND, 0, 0, 1));
			else begin
				pending.push_back(mk(snrt_pkg::ST_OK, k, 1, 1));
				if (f == snrt_pkg::FN_DELETE) begin
					for (i = k; i + 1 < tab_n; i++) begin
						tab_hi[i] = tab_hi[i+1]; tab_mid[i] = tab_mid[i+1];
						tab_lo[i] = tab_lo[i+1]; tab_ph[i] = tab_ph[i+1];
					end
					tab_n--;
				end
			end
		end
	endtask

	initial begin
		req.valid = 1'b0;
		req.func = snrt_pkg::FN_INSERT;
		req.key_hi = '0;
		req.key_mid = '0;
		req.key_lo = '0;
		req.phone_in = '0;
		rsp.ready = 1'b0;
	end

	// valid stays up after an accept until the next call or drain decides
	task automatic send_item(snrt_pkg::func_t f, logic [63:0] h, logic [63:0] m,
		logic [23:0] l, logic [31:0] p);
		while ($urandom_range(99, 0) < send_idle) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.func <= f;
		req.key_hi <= h;
		req.key_mid <= m;
		req.key_lo <= l;
		req.phone_in <= p;
		do @(posedge clk); while (!req.ready);
		predict_table(f, h, m, l, p);
	endtask

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		errors++;
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
	endtask

	// receiver: random ready plus optional long hold-off
	always @(posedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			rsp.ready <= 1'b0;
		end else rsp.ready <= ($urandom_range(99, 0) >= recv_idle);
	end

	always @(posedge clk) begin
		tb_snrt_pkg::answer_t w;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending.size() == 0) begin
				report_mismatch("unexpected item", 64'(rsp.status), '0);
			end else begin
				w = pending.pop_front();
				if (rsp.status !== w.status)
					report_mismatch("status", 64'(rsp.status), 64'(w.status));
				if (rsp.rec_hi !== w.hi) report_mismatch("rec_hi", rsp.rec_hi, w.hi);
				if (rsp.rec_mid !== w.mid) report_mismatch("rec_mid", rsp.rec_mid, w.mid);
				if (rsp.rec_lo !== w.lo)
					report_mismatch("rec_lo", 64'(rsp.rec_lo), 64'(w.lo));
				if (rsp.phone_out !== w.phone)
					report_mismatch("phone_out", 64'(unsigned'(rsp.phone_out)), 64'(w.phone));
				if (rsp.last !== w.last)
					report_mismatch("last", 64'(rsp.last), 64'(w.last));
			end
		end
	end

	task automatic drain_results();
		req.valid <= 1'b0;
		while (pending.size() != 0) @(posedge clk);
		repeat (4 * DEPTH + 10) @(posedge clk);
	endtask

	task automatic send_pool(snrt_pkg::func_t f, int i);
		send_item(f, pool_hi[i], pool_mid[i], pool_lo[i], $urandom());
	endtask

	task automatic test_empty_table();
		send_item(snrt_pkg::FN_LIST, '0, '0, '0, '0);
		send_item(snrt_pkg::FN_SEARCH, '1, '1, '1, '0);
		send_item(snrt_pkg::FN_DELETE, '0, '0, '0, '0);
	endtask

	task automatic test_extremes();
		send_item(snrt_pkg::FN_INSERT, '1, '1, '1, 32'h7fffffff);
		send_item(snrt_pkg::FN_INSERT, '0, '0, '0, 32'h80000000);
		send_item(snrt_pkg::FN_INSERT, 64'h4100000000000000, '0, 24'h000041, 32'hffffffff);
		send_item(snrt_pkg::FN_INSERT, '0, '0, '0, 32'd5); // duplicate name, stability
		send_item(snrt_pkg::FN_INSERT, 64'h8000000000000000, '0, '0, 32'd1); // top bit unsigned
		send_item(snrt_pkg::FN_LIST, '0, '0, '0, '0);
		send_item(snrt_pkg::FN_SEARCH, '0, '0, '0, '0);
		send_item(snrt_pkg::FN_SEARCH, '0, '0, 24'd1, '0);
		send_item(snrt_pkg::FN_DELETE, '0, '0, '0, '0);
		send_item(snrt_pkg::FN_DELETE, 64'h1, '0, '0, '0);
		send_item(snrt_pkg::FN_SEARCH, '0, '0, '0, '0);
		send_item(snrt_pkg::FN_LIST, '0, '0, '0, '0);
	endtask

	task automatic test_full_table();
		while (tab_n < DEPTH) send_pool(snrt_pkg::FN_INSERT, $urandom_range(7, 0));
		send_item(snrt_pkg::FN_INSERT, '1, '0, '1, '1);
		send_item(snrt_pkg::FN_LIST, '0, '0, '0, '0);
	endtask

	task automatic test_backpressure();
		hold_off = 300;
		repeat (6) send_pool(snrt_pkg::FN_SEARCH, $urandom_range(7, 0));
		send_item(snrt_pkg::FN_LIST, '0, '0, '0, '0);
		drain_results();
	endtask

	task automatic test_random(int count);
		int n;
		int r;
		for (n = 0; n < count; n++) begin
			r = $urandom_range(99, 0);
			if (r < 40) send_pool(snrt_pkg::FN_INSERT, $urandom_range(7, 0));
			else if (r < 50) send_item(snrt_pkg::FN_INSERT, {$urandom(), $urandom()},
				{$urandom(), $urandom()}, 24'($urandom()), $urandom());
			else if (r < 58) send_item(snrt_pkg::FN_LIST, {$urandom(), $urandom()}, '0, '0,
				$urandom());
			else if (r < 78) send_pool(snrt_pkg::FN_SEARCH, $urandom_range(7, 0));
			else if (r < 95) send_pool(snrt_pkg::FN_DELETE, $urandom_range(7, 0));
			else send_item(snrt_pkg::func_t'($urandom_range(3, 2)), {$urandom(), $urandom()},
				{$urandom(), $urandom()}, 24'($urandom()), '0);
		end
	endtask

	initial begin
		int i;
		for (i = 0; i < 8; i++) begin
			pool_hi[i] = (i < 4) ? {$urandom(), $urandom()} : {32'h41424300, 32'd0};
			pool_mid[i] = (i < 6) ? {$urandom(), $urandom()} : 64'd0;
			pool_lo[i] = 24'($urandom());
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		test_extremes();
		test_full_table();
		drain_results();
		test_backpressure();
		test_random(52);
		drain_results(); // sender pauses until all results are in
		send_idle = 84;
		recv_idle = 7;
		test_random(52);
		send_idle = 0;
		recv_idle = 0;
		test_random(52);
		drain_results();
		if (errors == 0) $display("** sorted_name_record_table_core: PASSED **");
		else $display("** sorted_name_record_table_core: FAILED **");
		$finish;
	end

	initial begin
		#8ms;
		$display("** sorted_name_record_table_core: FAILED **");
		$finish;
	end
endmodule
